// File: rtl/core/sfir_pkg.sv
// ----------------------------------------------------------------------------
// sfir_pkg
// Shared types and fixed widths for the streaming FIR filter.
// ----------------------------------------------------------------------------
package sfir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = SAMPLE_W - 1;
  localparam int INDEX_W  = 9;
  localparam int TAPS_W   = 10;

  typedef enum logic {
    FUNC_LOAD_COEF = 1'b0,
    FUNC_SAMPLE    = 1'b1
  } func_t;

  typedef struct packed {
    logic                       func;
    logic [INDEX_W-1:0]         coef_index;
    logic signed [SAMPLE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;
  } out_item_t;

  // Sequencer to MAC unit
  typedef struct packed {
    logic acc_clr;  // start of a new sample: zero the accumulator
    logic rd_vld;   // RAM read data is valid this cycle
  } mac_ctrl_t;

endpackage

// File: rtl/core/streaming_fir_filter.sv
// ----------------------------------------------------------------------------
// streaming_fir_filter
// Direct-form FIR filter over a circular delay line, one shared MAC unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_valid/in_stall/in_item) either load one Q1.15 coefficient
//   (func = load) into slot coef_index, or push one Q1.15 sample (func =
//   sample). A sample item yields one result item on out_valid/out_stall/
//   out_item: the sum of coef[k] * x[n-k] over k < tap_count, rounded half up
//   and saturated to Q1.15, with a flag when clamped.
//   cfg_we/cfg_wdata set tap_count (reset 512, clamped to MAX_TAPS); write it
//   only while the block is idle.
//   A coefficient load leaves the block idle for the next item. A sample
//   holds in_stall high from acceptance until its result is written to the
//   output register and out_valid rises, so no item is taken while a
//   sample is in work: the single multiply-accumulate unit handles one
//   tap per cycle, reading the coefficient and delay-line RAMs in step.
//   After reset the delay line is zeroed by a sweep over all MAX_TAPS slots
//   with in_stall high; cfg writes are taken during the sweep.
//   The result sits in an output register. While out_stall is high it holds,
//   and the next item may still be accepted; a finished sample then waits
//   for the register to free before the block takes another item.
// ----------------------------------------------------------------------------
module streaming_fir_filter #(
  parameter int MAX_TAPS = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sfir_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sfir_pkg::out_item_t           out_item,
  input  logic                          cfg_we,
  input  logic [sfir_pkg::TAPS_W-1:0]   cfg_wdata
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int SW = sfir_pkg::SAMPLE_W;

  logic [sfir_pkg::TAPS_W-1:0] tap_count_r;

  logic          coef_we, coef_re, dl_we, dl_re;
  logic [AW-1:0] coef_waddr, coef_raddr, dl_waddr, dl_raddr;
  logic [SW-1:0] coef_wdata, coef_rdata, dl_wdata, dl_rdata;

  sfir_pkg::mac_ctrl_t mac_ctrl;
  logic                mac_busy;
  sfir_pkg::out_item_t mac_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= sfir_pkg::TAPS_W'(512);
    end else if (cfg_we) begin
      tap_count_r <= cfg_wdata;
    end
  end

  sfir_seq #(
    .MAX_TAPS (MAX_TAPS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .tap_count  (tap_count_r),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_wdata (coef_wdata),
    .coef_re    (coef_re),
    .coef_raddr (coef_raddr),
    .dl_we      (dl_we),
    .dl_waddr   (dl_waddr),
    .dl_wdata   (dl_wdata),
    .dl_re      (dl_re),
    .dl_raddr   (dl_raddr),
    .mac_ctrl   (mac_ctrl),
    .mac_busy   (mac_busy),
    .mac_result (mac_result),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  sfir_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .re    (coef_re),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  sfir_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_TAPS)
  ) u_delay_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .re    (dl_re),
    .raddr (dl_raddr),
    .rdata (dl_rdata)
  );

  sfir_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .coef   (coef_rdata),
    .sample (dl_rdata),
    .busy   (mac_busy),
    .result (mac_result)
  );

endmodule

// File: rtl/core/sfir_ram.sv
// ----------------------------------------------------------------------------
// sfir_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/sfir_mac.sv
// ----------------------------------------------------------------------------
// sfir_mac
// Shared multiply-accumulate unit with rounding and output saturation.
// ----------------------------------------------------------------------------
module sfir_mac #(
  parameter int MAX_TAPS = 512
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sfir_pkg::mac_ctrl_t            ctrl,
  input  logic [sfir_pkg::SAMPLE_W-1:0]  coef,
  input  logic [sfir_pkg::SAMPLE_W-1:0]  sample,
  output logic                           busy,
  output sfir_pkg::out_item_t            result
);

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int SW    = sfir_pkg::SAMPLE_W;
  localparam int FW    = sfir_pkg::FRAC_W;
  localparam int PW    = 2 * SW;
  localparam int ACC_W = PW + AW + 1;
  localparam int QW    = ACC_W - FW;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FW - 1);
  localparam logic signed [QW-1:0]    Q_HI     = QW'((1 << FW) - 1);
  localparam logic signed [QW-1:0]    Q_LO     = -QW'(1 << FW);

  logic signed [PW-1:0]    mul_r;
  logic                    mul_vld_r;
  logic signed [ACC_W-1:0] acc_r;

  logic signed [ACC_W-1:0] rnd;
  logic signed [QW-1:0]    q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= ctrl.rd_vld;
    end
    if (ctrl.rd_vld) begin
      mul_r <= $signed(coef) * $signed(sample);
    end
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (mul_vld_r) begin
      acc_r <= acc_r + ACC_W'(mul_r);
    end
  end

  // Round half up, then floor-shift down to Q1.15
  always_comb begin
    rnd = acc_r + RND_HALF;
    q   = QW'(rnd >>> FW);
    if (q > Q_HI) begin
      result.sample_out = SW'(Q_HI);
      result.saturated  = 1'b1;
    end else if (q < Q_LO) begin
      result.sample_out = SW'(Q_LO);
      result.saturated  = 1'b1;
    end else begin
      result.sample_out = SW'(q);
      result.saturated  = 1'b0;
    end
  end

  assign busy = mul_vld_r;

endmodule

// File: rtl/core/sfir_seq.sv
// ----------------------------------------------------------------------------
// sfir_seq
// Sequencer: handshakes, delay-line clear sweep, tap address walk, result
// register.
// ----------------------------------------------------------------------------
module sfir_seq #(
  parameter int MAX_TAPS = 512
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  sfir_pkg::in_item_t                   in_item,
  input  logic [sfir_pkg::TAPS_W-1:0]          tap_count,
  output logic                                 coef_we,
  output logic [(MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1)-1:0] coef_waddr,
  output logic [sfir_pkg::SAMPLE_W-1:0]        coef_wdata,
  output logic                                 coef_re,
  output logic [(MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1)-1:0] coef_raddr,
  output logic                                 dl_we,
  output logic [(MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1)-1:0] dl_waddr,
  output logic [sfir_pkg::SAMPLE_W-1:0]        dl_wdata,
  output logic                                 dl_re,
  output logic [(MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1)-1:0] dl_raddr,
  output sfir_pkg::mac_ctrl_t                  mac_ctrl,
  input  logic                                 mac_busy,
  input  sfir_pkg::out_item_t                  mac_result,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output sfir_pkg::out_item_t                  out_item
);

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W = $clog2(MAX_TAPS + 1) > 0 ? $clog2(MAX_TAPS + 1) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_TAPS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       wp_r, wp_nxt;
  logic [AW-1:0]       dl_addr_r, dl_addr_nxt;
  logic [AW-1:0]       coef_addr_r, coef_addr_nxt;
  logic [CNT_W-1:0]    remain_r, remain_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                out_valid_r, out_valid_nxt;
  sfir_pkg::out_item_t out_item_r, out_item_nxt;

  logic             accept;
  logic             is_sample;
  logic [CNT_W-1:0] taps;
  logic [AW-1:0]    dl_addr_inc;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign is_sample = (in_item.func == sfir_pkg::FUNC_SAMPLE);
  assign taps      = (32'(tap_count) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(tap_count);
  assign dl_addr_inc = (dl_addr_r == LAST_SLOT) ? '0 : dl_addr_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    dl_addr_nxt   = dl_addr_r;
    coef_addr_nxt = coef_addr_r;
    remain_nxt    = remain_r;
    rd_vld_nxt    = 1'b0;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    // drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        dl_addr_nxt = dl_addr_inc;
        if (dl_addr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && is_sample) begin
          dl_addr_nxt   = wp_r;
          coef_addr_nxt = '0;
          remain_nxt    = taps;
          wp_nxt        = (wp_r == '0) ? LAST_SLOT : wp_r - 1'b1;
          state_nxt     = (taps == '0) ? S_DRAIN : S_RUN;
        end
      end
      S_RUN: begin
        rd_vld_nxt    = 1'b1;
        dl_addr_nxt   = dl_addr_inc;
        coef_addr_nxt = coef_addr_r + 1'b1;
        remain_nxt    = remain_r - 1'b1;
        if (remain_r == CNT_W'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_r && !mac_busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = mac_result;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      wp_r        <= LAST_SLOT;
      dl_addr_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      dl_addr_r   <= dl_addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    coef_addr_r <= coef_addr_nxt;
    remain_r    <= remain_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

  assign coef_we    = accept && !is_sample && (32'(in_item.coef_index) < MAX_TAPS);
  assign coef_waddr = AW'(in_item.coef_index);
  assign coef_wdata = in_item.value;
  assign coef_re    = (state_r == S_RUN);
  assign coef_raddr = coef_addr_r;

  assign dl_we    = (state_r == S_CLEAR) || (accept && is_sample);
  assign dl_waddr = (state_r == S_CLEAR) ? dl_addr_r : wp_r;
  assign dl_wdata = (state_r == S_CLEAR) ? '0 : in_item.value;
  assign dl_re    = (state_r == S_RUN);
  assign dl_raddr = dl_addr_r;

  assign mac_ctrl.acc_clr = accept && is_sample;
  assign mac_ctrl.rd_vld  = rd_vld_r;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: streaming FIR filter testbench
// Drives coefficient loads and samples through the valid/stall input channel
// and checks every filtered sample against an in-order predictor of the
// circular-buffer FIR. Covers several tap counts, from zero past the maximum,
// with random idling on both channels and a long output back-pressure period.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_TAPS       = 512;
  localparam int SAMPLE_MAX     = (1 << sfir_pkg::FRAC_W) - 1;
  localparam int SAMPLE_MIN     = -(1 << sfir_pkg::FRAC_W);
  localparam int CYCLE_LIMIT    = 4_000_000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 8;

  // Tracks coefficients, sample history and tap count; predicts each output.
  class fir_response_tracker;
    logic signed [sfir_pkg::SAMPLE_W-1:0] coef_mem [MAX_TAPS];
    bit                                   coef_loaded [MAX_TAPS];
    logic signed [sfir_pkg::SAMPLE_W-1:0] history [MAX_TAPS];
    logic [sfir_pkg::INDEX_W-1:0]         head;
    logic [sfir_pkg::TAPS_W-1:0]          tap_count;
    sfir_pkg::out_item_t                  expected_q [$];
    int                                   errors;

    function new();
      foreach (history[i]) begin
        history[i]     = '0;
        coef_mem[i]    = '0;
        coef_loaded[i] = 1'b0;
      end
      head      = sfir_pkg::INDEX_W'(MAX_TAPS - 1);
      tap_count = sfir_pkg::TAPS_W'(MAX_TAPS);
      errors    = 0;
    endfunction

    function int active_taps();
      return (tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void take_item(sfir_pkg::in_item_t it);
      longint                       acc;
      longint                       q;
      int                           taps;
      logic [sfir_pkg::INDEX_W-1:0] pos;
      sfir_pkg::out_item_t          res;
      if (it.func == sfir_pkg::FUNC_LOAD_COEF) begin
        coef_mem[it.coef_index]    = it.value;
        coef_loaded[it.coef_index] = 1'b1;
        return;
      end
      history[head] = it.value;
      taps = active_taps();
      acc  = 0;
      for (int k = 0; k < taps; k++) begin
        pos = head + sfir_pkg::INDEX_W'(k);
        acc += longint'(coef_mem[k]) * longint'(history[pos]);
      end
      head = head - 1'b1;
      // round half up, floor shift
      q = (taps == 0) ? 0 :
          (acc + (longint'(1) << (sfir_pkg::FRAC_W - 1))) >>> sfir_pkg::FRAC_W;
      res.saturated = 1'b0;
      if (q > SAMPLE_MAX) begin
        q = SAMPLE_MAX;
        res.saturated = 1'b1;
      end else if (q < SAMPLE_MIN) begin
        q = SAMPLE_MIN;
        res.saturated = 1'b1;
      end
      res.sample_out = q[sfir_pkg::SAMPLE_W-1:0];
      expected_q.push_back(res);
    endfunction

    function void match_result(sfir_pkg::out_item_t got);
      sfir_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, actual sample_out %0d saturated %0b",
                 $time, got.sample_out, got.saturated);
        return;
      end
      want = expected_q.pop_front();
      if (got.sample_out !== want.sample_out) begin
        errors++;
        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                 $time, want.sample_out, got.sample_out);
      end
      if (got.saturated !== want.saturated) begin
        errors++;
        $display("%0t: saturated mismatch, expected %0b, actual %0b",
                 $time, want.saturated, got.saturated);
      end
    endfunction
  endclass

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  sfir_pkg::in_item_t          in_item   = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b1;
  sfir_pkg::out_item_t         out_item;
  logic                        cfg_we    = 1'b0;
  logic [sfir_pkg::TAPS_W-1:0] cfg_wdata = '0;

  fir_response_tracker tracker;
  bit                  tx_idle     = 1'b1;
  bit                  rx_idle     = 1'b1;
  bit                  rx_hold_req = 1'b0;
  int                  cycle_count = 0;

  streaming_fir_filter #(.MAX_TAPS(MAX_TAPS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Result side: stall a random number of cycles per item, plus one long hold.
  initial begin : result_sink
    int gap;
    int hold_left;
    gap       = 0;
    hold_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        tracker.match_result(out_item);
        gap = rx_idle ? $urandom_range(0, 3) : 0;
      end
      if (rx_hold_req) begin
        hold_left   = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (gap > 0) begin
        out_stall <= 1'b1;
        gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic sfir_pkg::in_item_t make_item(input sfir_pkg::func_t f, input int idx,
                                                   input int val);
    sfir_pkg::in_item_t it;
    it.func       = f;
    it.coef_index = sfir_pkg::INDEX_W'(idx);
    it.value      = sfir_pkg::SAMPLE_W'(val);
    return it;
  endfunction

  function automatic int rand_value();
    unique case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return int'($urandom_range(0, 511)) - 256;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // Leaves valid high on return; the next call either keeps it or drops it.
  task automatic send_item(input sfir_pkg::in_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    tracker.take_item(it);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() > 0) @(posedge clk);
    // a coefficient load may still be in flight with nothing to wait on
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tap_count(input logic [sfir_pkg::TAPS_W-1:0] n);
    pause_until_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.tap_count = n;
  endtask

  // Every tap in use must hold a written coefficient before a sample goes in.
  task automatic load_missing_coefs();
    for (int k = 0; k < tracker.active_taps(); k++) begin
      if (!tracker.coef_loaded[k])
        send_item(make_item(sfir_pkg::FUNC_LOAD_COEF, k, rand_value()));
    end
  endtask

  task automatic random_phase(input int n_items, input int pause_at);
    for (int i = 0; i < n_items; i++) begin
      if (i == pause_at)
        pause_until_drained();
      if ($urandom_range(0, 3) == 0)
        send_item(make_item(sfir_pkg::FUNC_LOAD_COEF, $urandom_range(0, MAX_TAPS - 1),
                            rand_value()));
      else
        send_item(make_item(sfir_pkg::FUNC_SAMPLE, $urandom_range(0, MAX_TAPS - 1),
                            rand_value()));
    end
  endtask

  initial begin : stimulus
    int tap_plan [12];
    int taps;
    tap_plan = '{3, 16, 2, 1023, 40, 7, 1, 512, 64, 0, 11, 5};
    tracker = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty sum: every sample comes out as zero
    write_tap_count('0);
    send_item(make_item(sfir_pkg::FUNC_LOAD_COEF, 0, SAMPLE_MAX));
    send_item(make_item(sfir_pkg::FUNC_LOAD_COEF, MAX_TAPS - 1, SAMPLE_MIN));
    send_item(make_item(sfir_pkg::FUNC_SAMPLE, 0, SAMPLE_MAX));
    send_item(make_item(sfir_pkg::FUNC_SAMPLE, MAX_TAPS - 1, SAMPLE_MIN));

    // single tap: rounding and positive clamp
    write_tap_count(sfir_pkg::TAPS_W'(1));
    send_item(make_item(sfir_pkg::FUNC_SAMPLE, 0, SAMPLE_MAX));
    send_item(make_item(sfir_pkg::FUNC_LOAD_COEF, 0, SAMPLE_MIN));
    send_item(make_item(sfir_pkg::FUNC_SAMPLE, 0, SAMPLE_MIN));
    send_item(make_item(sfir_pkg::FUNC_SAMPLE, 0, SAMPLE_MAX));
    send_item(make_item(sfir_pkg::FUNC_LOAD_COEF, 0, 1));
    send_item(make_item(sfir_pkg::FUNC_SAMPLE, 0, 16384));
    send_item(make_item(sfir_pkg::FUNC_SAMPLE, 0, -16384));
    send_item(make_item(sfir_pkg::FUNC_SAMPLE, 0, -16385));
    send_item(make_item(sfir_pkg::FUNC_SAMPLE, 0, 0));

    // two taps: negative clamp
    write_tap_count(sfir_pkg::TAPS_W'(2));
    send_item(make_item(sfir_pkg::FUNC_LOAD_COEF, 0, SAMPLE_MIN));
    send_item(make_item(sfir_pkg::FUNC_LOAD_COEF, 1, SAMPLE_MIN));
    send_item(make_item(sfir_pkg::FUNC_SAMPLE, 0, SAMPLE_MAX));
    send_item(make_item(sfir_pkg::FUNC_SAMPLE, 0, SAMPLE_MAX));

    foreach (tap_plan[ph]) begin
      tx_idle = (ph % 3 != 1);
      rx_idle = (ph % 4 != 2);
      write_tap_count(sfir_pkg::TAPS_W'(tap_plan[ph]));
      load_missing_coefs();
      // short filter, so the output hold backs up into the input
      if (ph == 2)
        rx_hold_req = 1'b1;
      taps = tracker.active_taps();
      random_phase((taps >= MAX_TAPS) ? 20 : 60, (ph == 4) ? 30 : -1);
    end

    pause_until_drained();
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
